FILE: rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Action codes, character codes, the command word passed from the front
// end to the back end, and the back end state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  // default geometry
  localparam int COLUMNS_DEF     = 80;
  localparam int ROWS_DEF        = 25;
  localparam int TAB_STOP_DEF    = 8;
  localparam int QUEUE_DEPTH_DEF = 4;

  // field widths of the channels
  localparam int ACTION_W = 3;
  localparam int CHAR_W   = 8;
  localparam int ATTR_W   = 8;
  localparam int POS_X_W  = 7;
  localparam int POS_Y_W  = 5;
  localparam int CELL_W   = CHAR_W + ATTR_W;

  // widest cell address over the whole parameter range (256 x 128 cells)
  localparam int ADDR_MAX_W = 15;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUT_CHAR   = 3'd0,
    ACT_SET_CURSOR = 3'd1,
    ACT_CLEAR      = 3'd2,
    ACT_WRITE_CELL = 3'd3,
    ACT_READ_CELL  = 3'd4
  } action_t;

  // one classified word: memory work for the back end plus the result cursor
  typedef struct packed {
    logic                  wr;      // write chr/attr at addr
    logic                  rd;      // read cell at addr
    logic                  clear;   // blank the whole screen
    logic                  scroll;  // scroll up one row after the write
    logic [ADDR_MAX_W-1:0] addr;
    logic [CHAR_W-1:0]     chr;
    logic [ATTR_W-1:0]     attr;
    logic [POS_X_W-1:0]    col;
    logic [POS_Y_W-1:0]    row;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_INIT,
    BK_IDLE,
    BK_READ,
    BK_SCROLL,
    BK_FILL,
    BK_CLEAR,
    BK_DONE
  } back_state_t;

endpackage

`default_nettype wire

FILE: rtl/tcw_if.sv
// ----------------------------------------------------------------------------
// tcw_if: valid/ready channels of the text console writer
// tcw_in_if carries action words in, tcw_out_if carries result words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcw_in_if;
  logic                           valid;
  logic                           ready;
  logic [tcw_pkg::ACTION_W-1:0]   action;
  logic [tcw_pkg::CHAR_W-1:0]     char_code;
  logic [tcw_pkg::POS_X_W-1:0]    pos_x;
  logic [tcw_pkg::POS_Y_W-1:0]    pos_y;

  modport source (output valid, action, char_code, pos_x, pos_y, input ready);
  modport sink   (input valid, action, char_code, pos_x, pos_y, output ready);
endinterface

interface tcw_out_if;
  logic                           valid;
  logic                           ready;
  logic [tcw_pkg::POS_X_W-1:0]    cursor_col;
  logic [tcw_pkg::POS_Y_W-1:0]    cursor_row;
  logic [tcw_pkg::CHAR_W-1:0]     cell_char;
  logic [tcw_pkg::ATTR_W-1:0]     cell_attr;
  logic                           scrolled;

  modport source (output valid, cursor_col, cursor_row, cell_char, cell_attr, scrolled,
                  input ready);
  modport sink   (input valid, cursor_col, cursor_row, cell_char, cell_attr, scrolled,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front: action decode and cursor tracking
// Accepts action words, owns the cursor and the attribute register, and
// turns each word into a command for the back end with its result cursor.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_front #(
  parameter int COLUMNS  = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS     = tcw_pkg::ROWS_DEF,
  parameter int TAB_STOP = tcw_pkg::TAB_STOP_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  tcw_in_if.sink                          in_ch,
  input  wire logic                       cfg_we,
  input  wire logic [tcw_pkg::ATTR_W-1:0] cfg_wdata,
  input  wire logic                       init_done,
  input  wire logic                       q_ready,
  output logic                            q_push,
  output tcw_pkg::cmd_t                   q_data
);
  import tcw_pkg::*;

  localparam int CT     = COLUMNS * ROWS;
  localparam int AW     = $clog2(CT);
  localparam int CW     = $clog2(COLUMNS);
  localparam int RW     = $clog2(ROWS);
  localparam int PW     = $clog2(TAB_STOP);
  localparam int PW1    = PW + 1;
  localparam int DW     = $clog2(TAB_STOP + 1);
  localparam int SW     = CW + 2;          // column sum, up to three rows wide
  localparam int XW     = RW + 1;          // row that may run past the bottom
  localparam int BOT_PH = ((ROWS - 1) * COLUMNS) % TAB_STOP;

  logic [CW-1:0]     col_r, col_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic [PW-1:0]     ph_r, ph_nxt;     // linear cursor offset mod tab stop
  logic [ATTR_W-1:0] attr_r;

  // tab phase of each row start and of each column
  logic [PW-1:0] row_ph [ROWS];
  logic [PW-1:0] col_ph [COLUMNS];

  for (genvar g = 0; g < ROWS; g++) begin : g_row_ph
    localparam int RP = (g * COLUMNS) % TAB_STOP;
    assign row_ph[g] = PW'(RP);
  end

  for (genvar g = 0; g < COLUMNS; g++) begin : g_col_ph
    localparam int CP = g % TAB_STOP;
    assign col_ph[g] = PW'(CP);
  end

  function automatic logic [AW-1:0] cell_addr(logic [RW-1:0] r, logic [CW-1:0] c);
    return AW'(r) * AW'(COLUMNS) + AW'(c);
  endfunction

  logic            accept;
  logic [DW-1:0]   tab_dist;
  logic [SW-1:0]   sum;
  logic [XW-1:0]   rowx;
  logic [PW-1:0]   pc_ph;
  logic            pc_wr;
  logic            pc_scroll;
  logic [CW-1:0]   cx;
  logic [RW-1:0]   cy;
  logic            xy_ok;
  logic [PW1-1:0]  xy_ph;

  assign in_ch.ready = init_done && q_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign q_push      = accept;

  // put char: next cursor in column/row form plus tab phase
  always_comb begin
    tab_dist  = DW'(TAB_STOP) - DW'(ph_r);
    sum       = '0;
    rowx      = {1'b0, row_r};
    pc_ph     = '0;
    pc_wr     = 1'b0;
    case (in_ch.char_code)
      CH_NEWLINE: begin
        rowx = {1'b0, row_r} + 1'b1;
        if (rowx < XW'(ROWS)) begin
          pc_ph = row_ph[rowx[RW-1:0]];
        end
      end
      CH_TAB: begin
        sum = SW'(col_r) + SW'(tab_dist);
        if (sum >= SW'(2 * COLUMNS)) begin
          sum  = sum - SW'(2 * COLUMNS);
          rowx = rowx + XW'(2);
        end else if (sum >= SW'(COLUMNS)) begin
          sum  = sum - SW'(COLUMNS);
          rowx = rowx + 1'b1;
        end
      end
      default: begin
        pc_wr = 1'b1;
        sum   = SW'(col_r) + 1'b1;
        if (sum == SW'(COLUMNS)) begin
          sum  = '0;
          rowx = rowx + 1'b1;
        end
        pc_ph = (ph_r == PW'(TAB_STOP - 1)) ? '0 : ph_r + 1'b1;
      end
    endcase
    pc_scroll = (rowx >= XW'(ROWS));
  end

  // set cursor saturation and write/read range check
  always_comb begin
    cx    = ({2'b00, in_ch.pos_x} < 9'(COLUMNS)) ? CW'(in_ch.pos_x) : CW'(COLUMNS - 1);
    cy    = ({3'b000, in_ch.pos_y} < 8'(ROWS)) ? RW'(in_ch.pos_y) : RW'(ROWS - 1);
    xy_ok = ({2'b00, in_ch.pos_x} < 9'(COLUMNS)) && ({3'b000, in_ch.pos_y} < 8'(ROWS));
    xy_ph = PW1'(row_ph[cy]) + PW1'(col_ph[cx]);
    if (xy_ph >= PW1'(TAB_STOP)) begin
      xy_ph = xy_ph - PW1'(TAB_STOP);
    end
  end

  // command word and next cursor
  always_comb begin
    col_nxt       = col_r;
    row_nxt       = row_r;
    ph_nxt        = ph_r;
    q_data        = '0;
    q_data.chr    = in_ch.char_code;
    q_data.attr   = attr_r;
    case (in_ch.action)
      ACT_PUT_CHAR: begin
        q_data.wr     = pc_wr;
        q_data.addr   = ADDR_MAX_W'(cell_addr(row_r, col_r));
        q_data.scroll = pc_scroll;
        if (pc_scroll) begin
          col_nxt = '0;
          row_nxt = RW'(ROWS - 1);
          ph_nxt  = PW'(BOT_PH);
        end else begin
          col_nxt = CW'(sum);
          row_nxt = RW'(rowx);
          ph_nxt  = pc_ph;
        end
      end
      ACT_SET_CURSOR: begin
        col_nxt = cx;
        row_nxt = cy;
        ph_nxt  = PW'(xy_ph);
      end
      ACT_CLEAR: begin
        q_data.clear = 1'b1;
        col_nxt      = '0;
        row_nxt      = '0;
        ph_nxt       = '0;
      end
      ACT_WRITE_CELL: begin
        q_data.wr   = xy_ok;
        q_data.addr = ADDR_MAX_W'(cell_addr(cy, cx));
      end
      ACT_READ_CELL: begin
        q_data.rd   = xy_ok;
        q_data.addr = ADDR_MAX_W'(cell_addr(cy, cx));
      end
      default: begin
      end
    endcase
    q_data.col = POS_X_W'(col_nxt);
    q_data.row = POS_Y_W'(row_nxt);
  end

  // cursor and attribute registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      ph_r   <= '0;
      attr_r <= ATTR_RESET;
    end else begin
      if (cfg_we) begin
        attr_r <= cfg_wdata;
      end
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
        ph_r  <= ph_nxt;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tcw_queue.sv
// ----------------------------------------------------------------------------
// tcw_queue: command queue between front and back end
// Small register FIFO so decode keeps going while the back end sweeps.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_queue #(
  parameter int DEPTH = tcw_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire tcw_pkg::cmd_t push_data,
  output logic               not_full,
  input  wire logic          pop,
  output logic               head_valid,
  output tcw_pkg::cmd_t      head_data
);
  import tcw_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign not_full   = (count_r != CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = slots_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tcw_back.sv
// ----------------------------------------------------------------------------
// tcw_back: screen store and sweep sequencer
// Holds the cell memory, carries out writes, reads, scroll and clear
// sweeps, and drives the registered result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_back #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire tcw_pkg::cmd_t q_head,
  output logic               q_pop,
  output logic               init_done,
  tcw_out_if.source          out_ch
);
  import tcw_pkg::*;

  localparam int CT = COLUMNS * ROWS;
  localparam int AW = $clog2(CT);
  localparam int NW = $clog2(CT + 1);

  back_state_t state_r, state_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  cmd_t          cmd_r, cmd_nxt;

  // cell memory, one write and one registered read per cycle
  logic [CELL_W-1:0] mem [CT];
  logic [CELL_W-1:0] mem_rd_r;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_wa, mem_ra;
  logic [CELL_W-1:0] mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_rd_r <= mem[mem_ra];
    end
  end

  // result register
  logic                  out_valid_r;
  logic [POS_X_W-1:0]    out_col_r;
  logic [POS_Y_W-1:0]    out_row_r;
  logic [CHAR_W-1:0]     out_char_r;
  logic [ATTR_W-1:0]     out_attr_r;
  logic                  out_scr_r;
  logic                  slot_free;
  logic                  load;
  cmd_t                  ld_cmd;
  logic [CHAR_W-1:0]     ld_char;
  logic [ATTR_W-1:0]     ld_attr;
  logic [CELL_W-1:0]     blank;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign init_done = (state_r != BK_INIT);
  assign blank     = {cmd_r.attr, CH_SPACE};

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd_nxt   = cmd_r;
    q_pop     = 1'b0;
    mem_we    = 1'b0;
    mem_wa    = '0;
    mem_wd    = '0;
    mem_re    = 1'b0;
    mem_ra    = '0;
    load      = 1'b0;
    ld_cmd    = cmd_r;
    ld_char   = '0;
    ld_attr   = '0;
    case (state_r)
      BK_INIT: begin
        mem_we = 1'b1;
        mem_wa = cnt_r[AW-1:0];
        if (cnt_r == NW'(CT - 1)) begin
          cnt_nxt   = '0;
          state_nxt = BK_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      BK_IDLE: begin
        if (q_valid && slot_free) begin
          q_pop   = 1'b1;
          cmd_nxt = q_head;
          if (q_head.wr) begin
            mem_we = 1'b1;
            mem_wa = q_head.addr[AW-1:0];
            mem_wd = {q_head.attr, q_head.chr};
          end
          if (q_head.rd) begin
            mem_re    = 1'b1;
            mem_ra    = q_head.addr[AW-1:0];
            state_nxt = BK_READ;
          end else if (q_head.clear) begin
            cnt_nxt   = '0;
            state_nxt = BK_CLEAR;
          end else if (q_head.scroll) begin
            cnt_nxt   = NW'(COLUMNS);
            state_nxt = BK_SCROLL;
          end else begin
            load   = 1'b1;
            ld_cmd = q_head;
          end
        end
      end
      BK_READ: begin
        load      = 1'b1;
        ld_char   = mem_rd_r[CHAR_W-1:0];
        ld_attr   = mem_rd_r[CELL_W-1:CHAR_W];
        state_nxt = BK_IDLE;
      end
      BK_SCROLL: begin
        // read one row below, write back the word read the cycle before
        if (cnt_r != NW'(CT)) begin
          mem_re = 1'b1;
          mem_ra = cnt_r[AW-1:0];
        end
        if (cnt_r != NW'(COLUMNS)) begin
          mem_we = 1'b1;
          mem_wa = AW'(cnt_r - NW'(COLUMNS + 1));
          mem_wd = mem_rd_r;
        end
        if (cnt_r == NW'(CT)) begin
          cnt_nxt   = NW'(CT - COLUMNS);
          state_nxt = BK_FILL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      BK_FILL, BK_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = cnt_r[AW-1:0];
        mem_wd = blank;
        if (cnt_r == NW'(CT - 1)) begin
          state_nxt = BK_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      BK_DONE: begin
        load      = 1'b1;
        state_nxt = BK_IDLE;
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_INIT;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_col_r  <= ld_cmd.col;
      out_row_r  <= ld_cmd.row;
      out_char_r <= ld_char;
      out_attr_r <= ld_attr;
      out_scr_r  <= ld_cmd.scroll;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.cursor_col = out_col_r;
  assign out_ch.cursor_row = out_row_r;
  assign out_ch.cell_char  = out_char_r;
  assign out_ch.cell_attr  = out_attr_r;
  assign out_ch.scrolled   = out_scr_r;

endmodule

`default_nettype wire

FILE: rtl/text_console_writer.sv
// Text console writer. Keeps a COLUMNS x ROWS screen of character/attribute
// cells and a cursor, and answers every action word with one result word.
// Put char (ordinary byte, newline or tab), set cursor, write cell and
// unknown actions finish in the idle state, so back to back they run at one
// word per cycle while the result channel is not stalled; read cell also
// passes the read state for the registered memory read. Clear and a put
// char that scrolls are swept one cell per cycle through the single write
// port of the screen memory. After reset the block zeroes every screen cell
// with in_ch.ready low; cfg_we writes are taken throughout. The command
// queue lets new words be accepted while a sweep is running, up to
// QUEUE_DEPTH words.
// ----------------------------------------------------------------------------
// text_console_writer: text-mode teletype console engine, top level
// Front end decode, command queue and screen store back end.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer #(
  parameter int COLUMNS     = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS        = tcw_pkg::ROWS_DEF,
  parameter int TAB_STOP    = tcw_pkg::TAB_STOP_DEF,
  parameter int QUEUE_DEPTH = tcw_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  tcw_in_if.sink                          in_ch,
  tcw_out_if.source                       out_ch,
  input  wire logic                       cfg_we,
  input  wire logic [tcw_pkg::ATTR_W-1:0] cfg_wdata
);
  import tcw_pkg::*;

  logic  q_push, q_not_full, q_pop, q_valid, init_done;
  cmd_t  q_wdata, q_head;

  tcw_front #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .init_done (init_done),
    .q_ready   (q_not_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  tcw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_wdata),
    .not_full   (q_not_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .init_done (init_done),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

FILE: rtl/tcw_checker.sv
// ----------------------------------------------------------------------------
// tcw_checker: port-level checks of the text console writer
// Watches the top level ports over time; attached with a bind.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_checker #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [tcw_pkg::POS_X_W-1:0] out_col,
  input wire logic [tcw_pkg::POS_Y_W-1:0] out_row,
  input wire logic [tcw_pkg::CHAR_W-1:0]  out_char,
  input wire logic [tcw_pkg::ATTR_W-1:0]  out_attr,
  input wire logic                        out_scrolled
);

  // screen memory is being zeroed right after reset: no word taken
  a_init_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_ready)
    else $error("input accepted during post-reset clearing pass");

  // nothing to report right after reset
  a_no_result_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result shown right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_col) && $stable(out_row)
      && $stable(out_char) && $stable(out_attr) && $stable(out_scrolled))
    else $error("stalled result changed");

  // cursor always on screen
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_col) < COLUMNS) && (32'(out_row) < ROWS))
    else $error("cursor off screen");

  // a scroll leaves the cursor at the start of the bottom row
  a_scroll_home: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_scrolled |-> (out_col == '0)
      && (out_row == tcw_pkg::POS_Y_W'(ROWS - 1)))
    else $error("scroll left cursor off bottom row start");

endmodule

bind text_console_writer tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_col      (out_ch.cursor_col),
  .out_row      (out_ch.cursor_row),
  .out_char     (out_ch.cell_char),
  .out_attr     (out_ch.cell_attr),
  .out_scrolled (out_ch.scrolled)
);

`default_nettype wire

FILE: dv/tcw_console_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_console_checker: screen and cursor predictor with result comparison
// Watches the action and result channels and the attribute write port. It
// keeps its own screen, cursor and attribute, predicts the status word of
// every accepted action word, and compares each result word with the oldest
// prediction.
// ----------------------------------------------------------------------------
module tcw_console_checker #(
  parameter int COLUMNS  = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS     = tcw_pkg::ROWS_DEF,
  parameter int TAB_STOP = tcw_pkg::TAB_STOP_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  tcw_in_if                          in_mon,
  tcw_out_if                         out_mon,
  input  logic                       cfg_we,
  input  logic [tcw_pkg::ATTR_W-1:0] cfg_wdata,
  output int                         fail_count,
  output int                         pending_count,
  output int                         checked_count,
  output int                         scroll_count,
  output int                         read_count
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;

  typedef struct packed {
    logic [POS_X_W-1:0] cursor_col;
    logic [POS_Y_W-1:0] cursor_row;
    logic [CHAR_W-1:0]  cell_char;
    logic [ATTR_W-1:0]  cell_attr;
    logic               scrolled;
  } status_t;

  // model state
  logic [CELL_W-1:0] screen_mem [CELLS];
  int unsigned       cursor_pos;
  logic [ATTR_W-1:0] text_attr;

  status_t expected_status [$];

  // apply one action word to the model screen, return the status word
  function automatic status_t console_step(logic [ACTION_W-1:0] act, logic [CHAR_W-1:0] ch,
                                           logic [POS_X_W-1:0] x, logic [POS_Y_W-1:0] y);
    status_t     res;
    int unsigned pos;
    int unsigned cx;
    int unsigned cy;
    res = '0;
    pos = cursor_pos;
    cx  = (x < COLUMNS) ? x : COLUMNS - 1;
    cy  = (y < ROWS) ? y : ROWS - 1;
    case (act)
      ACT_PUT_CHAR: begin
        if (ch == CH_NEWLINE) begin
          pos = pos + COLUMNS - (pos % COLUMNS);
        end else if (ch == CH_TAB) begin
          pos = pos + TAB_STOP - (pos % TAB_STOP);
        end else begin
          if (pos < CELLS) screen_mem[pos] = {text_attr, ch};
          pos = pos + 1;
        end
        // past the last cell: scroll up one row, blank the bottom row
        if (pos >= CELLS) begin
          for (int i = 0; i < CELLS - COLUMNS; i++) screen_mem[i] = screen_mem[i + COLUMNS];
          for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_mem[i] = {text_attr, CH_SPACE};
          pos = CELLS - COLUMNS;
          res.scrolled = 1'b1;
        end
        cursor_pos = pos;
      end
      ACT_SET_CURSOR: begin
        cursor_pos = cy * COLUMNS + cx;
      end
      ACT_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen_mem[i] = {text_attr, CH_SPACE};
        cursor_pos = 0;
      end
      ACT_WRITE_CELL: begin
        if (x < COLUMNS && y < ROWS) screen_mem[y * COLUMNS + x] = {text_attr, ch};
      end
      ACT_READ_CELL: begin
        if (x < COLUMNS && y < ROWS) begin
          {res.cell_attr, res.cell_char} = screen_mem[y * COLUMNS + x];
        end
      end
      default: ;
    endcase
    res.cursor_col = POS_X_W'(cursor_pos % COLUMNS);
    res.cursor_row = POS_Y_W'(cursor_pos / COLUMNS);
    return res;
  endfunction

  always @(posedge clk) begin
    status_t want;
    status_t got;
    if (!rst_n) begin
      for (int i = 0; i < CELLS; i++) screen_mem[i] = '0;
      cursor_pos = 0;
      text_attr  = ATTR_RESET;
      expected_status.delete();
      pending_count = 0;
    end else begin
      // result word out: compare with the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.cursor_col, out_mon.cursor_row, out_mon.cell_char,
               out_mon.cell_attr, out_mon.scrolled};
        if (expected_status.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: result word with nothing expected", $realtime);
            $display("  got col %0d row %0d char %h attr %h scr %0d",
                     got.cursor_col, got.cursor_row, got.cell_char, got.cell_attr,
                     got.scrolled);
          end
        end else begin
          want = expected_status.pop_front();
          checked_count++;
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: result %0d mismatch", $realtime, checked_count);
              $display("  exp col %0d row %0d char %h attr %h scr %0d",
                       want.cursor_col, want.cursor_row, want.cell_char,
                       want.cell_attr, want.scrolled);
              $display("  got col %0d row %0d char %h attr %h scr %0d",
                       got.cursor_col, got.cursor_row, got.cell_char,
                       got.cell_attr, got.scrolled);
            end
          end
        end
      end
      // action word in: predict its status word with the attribute it saw
      if (in_mon.valid && in_mon.ready) begin
        want = console_step(in_mon.action, in_mon.char_code, in_mon.pos_x, in_mon.pos_y);
        if (in_mon.action == ACT_READ_CELL) read_count++;
        if (want.scrolled) scroll_count++;
        expected_status.push_back(want);
      end
      // attribute register write, seen by later words
      if (cfg_we) text_attr = cfg_wdata;
      pending_count = expected_status.size();
    end
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: text console writer regression
// Drives directed and random action words with random idling on both
// channels, steps the attribute register through several values between
// phases, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb;
  import tcw_pkg::*;

  localparam int COLS      = COLUMNS_DEF;
  localparam int ROWS      = ROWS_DEF;
  localparam int CELLS     = COLS * ROWS;
  localparam logic [POS_X_W-1:0] X_MAX = '1;
  localparam logic [POS_Y_W-1:0] Y_MAX = '1;
  localparam int PHASES    = 5;
  localparam int PHASE_LEN = 170;

  // action codes the block does not define
  localparam logic [ACTION_W-1:0] ACT_UNDEF_5 = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_UNDEF_6 = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_UNDEF_7 = 3'd7;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [ATTR_W-1:0] cfg_wdata;
  bit                quiet;
  int                fail_count;
  int                pending_count;
  int                checked_count;
  int                scroll_count;
  int                read_count;
  int                attr_writes;

  tcw_in_if  in_ch ();
  tcw_out_if out_ch ();

  text_console_writer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  tcw_console_checker #(
    .COLUMNS  (COLS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP_DEF)
  ) chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .checked_count (checked_count),
    .scroll_count  (scroll_count),
    .read_count    (read_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop
  initial begin
    #(30_000_000);
    $display("text_console_writer regression: fail");
    $finish;
  end

  // result side back-pressure in random bursts
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // present one action word and hold it until taken
  task automatic send_word(logic [ACTION_W-1:0] act, logic [CHAR_W-1:0] ch,
                           logic [POS_X_W-1:0] x, logic [POS_Y_W-1:0] y);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.action    <= act;
    in_ch.char_code <= ch;
    in_ch.pos_x     <= x;
    in_ch.pos_y     <= y;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // drain all results, let any sweep finish, then write the attribute
  task automatic set_attr(logic [ATTR_W-1:0] value);
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
    repeat (CELLS + 8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    attr_writes++;
  endtask

  // one random action word, weighted toward printing near the screen end
  task automatic random_word();
    int                 pick;
    logic [CHAR_W-1:0]  ch;
    logic [POS_X_W-1:0] x;
    logic [POS_Y_W-1:0] y;
    logic [POS_X_W-1:0] ux;
    logic [POS_Y_W-1:0] uy;
    pick = $urandom_range(0, 99);
    ch   = CHAR_W'($urandom_range(0, 255));
    x    = ($urandom_range(0, 9) == 0) ? POS_X_W'($urandom_range(COLS, X_MAX))
                                        : POS_X_W'($urandom_range(0, COLS - 1));
    y    = ($urandom_range(0, 9) == 0) ? POS_Y_W'($urandom_range(ROWS, Y_MAX))
                                        : POS_Y_W'($urandom_range(0, ROWS - 1));
    ux   = POS_X_W'($urandom_range(0, X_MAX));
    uy   = POS_Y_W'($urandom_range(0, Y_MAX));
    if (pick < 55) begin
      case ($urandom_range(0, 15))
        0: ch = CH_NEWLINE;
        1: ch = CH_TAB;
        default: ;
      endcase
      send_word(ACT_PUT_CHAR, ch, x, y);
    end else if (pick < 67) begin
      if ($urandom_range(0, 4) < 2) y = POS_Y_W'(ROWS - 1);
      if ($urandom_range(0, 2) == 0) x = POS_X_W'($urandom_range(COLS - 8, COLS - 1));
      send_word(ACT_SET_CURSOR, ch, x, y);
    end else if (pick < 77) begin
      send_word(ACT_WRITE_CELL, ch, x, y);
    end else if (pick < 93) begin
      send_word(ACT_READ_CELL, ch, x, y);
    end else if (pick < 95) begin
      send_word(ACT_CLEAR, ch, x, y);
    end else begin
      case ($urandom_range(0, 2))
        0: send_word(ACT_UNDEF_5, ch, ux, uy);
        1: send_word(ACT_UNDEF_6, ch, ux, uy);
        default: send_word(ACT_UNDEF_7, ch, ux, uy);
      endcase
    end
  endtask

  initial begin
    logic [ATTR_W-1:0] phase_attr [PHASES];
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    quiet           = 1'b0;
    attr_writes     = 0;
    in_ch.valid     = 1'b0;
    in_ch.action    = ACT_PUT_CHAR;
    in_ch.char_code = '0;
    in_ch.pos_x     = '0;
    in_ch.pos_y     = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset screen content and reset attribute
    send_word(ACT_READ_CELL, 8'h00, 7'd0, 5'd0);
    send_word(ACT_PUT_CHAR, 8'h41, 7'd0, 5'd0);
    send_word(ACT_READ_CELL, 8'h00, 7'd0, 5'd0);

    set_attr(8'h00);
    // character zero, top code, tab and newline
    send_word(ACT_PUT_CHAR, 8'h00, 7'd0, 5'd0);
    send_word(ACT_PUT_CHAR, 8'hFF, X_MAX, Y_MAX);
    send_word(ACT_PUT_CHAR, CH_TAB, 7'd0, 5'd0);
    send_word(ACT_PUT_CHAR, CH_NEWLINE, 7'd0, 5'd0);
    // cursor saturation, then print into the last cell to scroll
    send_word(ACT_SET_CURSOR, 8'h00, X_MAX, Y_MAX);
    send_word(ACT_PUT_CHAR, 8'h5A, 7'd0, 5'd0);
    send_word(ACT_READ_CELL, 8'h00, POS_X_W'(COLS - 1), POS_Y_W'(ROWS - 2));
    send_word(ACT_READ_CELL, 8'h00, POS_X_W'(COLS - 1), POS_Y_W'(ROWS - 1));
    // tab and newline past the end scroll too
    send_word(ACT_SET_CURSOR, 8'h00, POS_X_W'(COLS - 5), POS_Y_W'(ROWS - 1));
    send_word(ACT_PUT_CHAR, CH_TAB, 7'd0, 5'd0);
    send_word(ACT_PUT_CHAR, CH_NEWLINE, 7'd0, 5'd0);
    // cell writes in and out of range
    send_word(ACT_WRITE_CELL, 8'h51, POS_X_W'(COLS - 1), POS_Y_W'(ROWS - 1));
    send_word(ACT_WRITE_CELL, 8'hAA, POS_X_W'(COLS), 5'd0);
    send_word(ACT_WRITE_CELL, 8'hAA, 7'd0, POS_Y_W'(ROWS));
    send_word(ACT_WRITE_CELL, 8'hAA, X_MAX, Y_MAX);
    send_word(ACT_READ_CELL, 8'h00, POS_X_W'(COLS - 1), POS_Y_W'(ROWS - 1));
    send_word(ACT_READ_CELL, 8'h00, POS_X_W'(COLS), POS_Y_W'(ROWS - 1));
    send_word(ACT_READ_CELL, 8'h00, X_MAX, Y_MAX);
    // undefined actions leave everything alone
    send_word(ACT_UNDEF_5, 8'hFF, X_MAX, Y_MAX);
    send_word(ACT_UNDEF_6, 8'h00, 7'd0, 5'd0);
    send_word(ACT_UNDEF_7, 8'h0A, 7'd5, 5'd3);
    send_word(ACT_CLEAR, 8'h00, 7'd0, 5'd0);
    send_word(ACT_READ_CELL, 8'h00, 7'd0, 5'd0);

    // random phases, one attribute setting each; the last one runs flat out
    phase_attr[0] = 8'hFF;
    phase_attr[1] = ATTR_W'($urandom_range(0, 255));
    phase_attr[2] = 8'hA5;
    phase_attr[3] = 8'h5A;
    phase_attr[4] = ATTR_W'($urandom_range(0, 255));
    for (int p = 0; p < PHASES; p++) begin
      set_attr(phase_attr[p]);
      if (p == PHASES - 1) quiet = 1'b1;
      for (int n = 0; n < PHASE_LEN; n++) random_word();
    end

    // drain and let the block settle
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
    repeat (CELLS + 8) @(posedge clk);

    $display("checked %0d result words: %0d cell reads, %0d scrolls, %0d attribute settings",
             checked_count, read_count, scroll_count, attr_writes);
    if (fail_count == 0 && pending_count == 0) begin
      $display("text_console_writer regression: pass");
    end else begin
      $display("%0d failures", fail_count);
      $display("text_console_writer regression: fail");
    end
    $finish;
  end

endmodule
